[src/rss_pkg.sv]
// shared types, constants and helpers for the ray/sphere shade accumulator
// no dependencies; imported by the interfaces and by every module
`default_nettype none

package rss_pkg;

  // grid geometry
  localparam int GRID_SIZE  = 1024;
  localparam int GRID_W     = $clog2(GRID_SIZE);
  localparam int GRID_CELLS = GRID_SIZE * GRID_SIZE;
  localparam int GRID_AW    = $clog2(GRID_CELLS);

  // shared divider: 48 bit dividend, 32 bit divisor
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW);

  // shared root unit: 64 bit radicand, 32 bit root
  localparam int SQ_W  = 64;
  localparam int SQ_RW = 32;
  localparam int SQ_CW = $clog2(SQ_RW);

  localparam int ONE_Q16 = 65536;

  // configuration register indexes
  localparam logic [2:0] CFG_LIGHT_X     = 3'd0;
  localparam logic [2:0] CFG_LIGHT_Y     = 3'd1;
  localparam logic [2:0] CFG_LIGHT_Z     = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y    = 3'd3;
  localparam logic [2:0] CFG_RADIUS      = 3'd4;
  localparam logic [2:0] CFG_WIN_DIST    = 3'd5;
  localparam logic [2:0] CFG_WIN_HALF    = 3'd6;

  // reset values
  localparam logic [31:0] RST_LIGHT_X  = 32'h0004_0000;
  localparam logic [31:0] RST_LIGHT_Y  = 32'h0004_0000;
  localparam logic [31:0] RST_LIGHT_Z  = 32'hFFFF_0000;
  localparam logic [31:0] RST_CENTER_Y = 32'h000C_0000;
  localparam logic [30:0] RST_RADIUS   = 31'h0006_0000;
  localparam logic [30:0] RST_WIN_DIST = 31'h000A_0000;
  localparam logic [30:0] RST_WIN_HALF = 31'h000A_0000;

  // operation codes
  localparam logic OP_TRACE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [SQ_RW-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [GRID_AW-1:0] addr;
    logic [31:0]        data;
  } grid_req_t;

  // clamp a Q1.16 direction component to [-1.0, 1.0]
  function automatic logic signed [17:0] clamp_dir(input logic signed [17:0] v);
    logic signed [17:0] r;
    r = v;
    if (v > 18'sd65536) r = 18'sd65536;
    else if (v < -18'sd65536) r = -18'sd65536;
    return r;
  endfunction

endpackage

`default_nettype wire

[src/rss_if.sv]
// valid/ready channel interfaces for trace/read items and result words
// depends on rss_pkg
`default_nettype none

interface rss_req_if
  import rss_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;
  logic signed [17:0] dir_z;
  logic [9:0]         read_row;
  logic [9:0]         read_col;

  modport source (output valid, opcode, dir_x, dir_y, dir_z, read_row, read_col,
                  input ready);
  modport sink   (input valid, opcode, dir_x, dir_y, dir_z, read_row, read_col,
                  output ready);
endinterface

interface rss_rsp_if
  import rss_pkg::*;
  ;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [9:0]  hit_row;
  logic [9:0]  hit_col;
  logic [16:0] brightness;
  logic [31:0] cell_value;

  modport source (output valid, accepted, hit_row, hit_col, brightness, cell_value,
                  input ready);
  modport sink   (input valid, accepted, hit_row, hit_col, brightness, cell_value,
                  output ready);
endinterface

`default_nettype wire

[src/rss_div.sv]
// restoring unsigned divider, one quotient bit per cycle
// depends on rss_pkg
`default_nettype none

module rss_div
  import rss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] dvs;
  logic              done;

  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] diff;
  logic              ge;

  always_comb begin
    shifted = {rem, quo[DIV_NW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    ge      = ~diff[DIV_DW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

`default_nettype wire

[src/rss_sqrt.sv]
// digit-by-digit integer square root, one root bit per cycle
// depends on rss_pkg
`default_nettype none

module rss_sqrt
  import rss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sqrt_req_t req,
  output sqrt_rsp_t      rsp
);

  logic             busy;
  logic             done;
  logic [SQ_CW-1:0] cnt;
  logic [SQ_W-1:0]  x;
  logic [SQ_RW+1:0] rem;
  logic [SQ_RW-1:0] root;

  logic [SQ_RW+3:0] shifted;
  logic [SQ_RW+3:0] trial;
  logic             ge;

  always_comb begin
    shifted = {rem, x[SQ_W-1 -: 2]};
    trial   = {2'b00, root, 2'b01};
    ge      = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= req.radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= ge ? SQ_RW'(0) + (SQ_RW+2)'(shifted - trial) : (SQ_RW+2)'(shifted);
        root <= {root[SQ_RW-2:0], ge};
        x    <= {x[SQ_W-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == SQ_CW'(SQ_RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

`default_nettype wire

[src/rss_grid.sv]
// brightness grid memory, one port, registered read data
// clears every cell after reset, one cell per cycle; depends on rss_pkg
`default_nettype none

module rss_grid
  import rss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire grid_req_t req,
  output logic [31:0]    rd_data,
  output logic           clearing
);

  logic [31:0]        mem [GRID_CELLS];
  logic [GRID_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == GRID_AW'(GRID_CELLS - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr] <= '0;
    else if (req.wr) mem[req.addr] <= req.data;
    if (req.rd) rd_data <= mem[req.addr];
  end

endmodule

`default_nettype wire

[src/ray_sphere_shade_accumulate_top.sv]
// top level of the ray/sphere shade accumulator: sequencer, shared multiplier,
// configuration registers; depends on rss_pkg, rss_if, rss_div, rss_sqrt, rss_grid
//
// usage
//   req carries one word per item: opcode trace takes dir_x/y/z, opcode read
//   takes read_row/read_col. rsp carries one result word per item.
//   cfg_we/cfg_index/cfg_data write the seven geometry registers; the user must
//   write them only while the block is idle, which the block itself does not
//   enforce; index 7 is ignored.
// timing
//   one item is worked on at a time. a read passes the grid address and data
//   states before its result is registered. a trace reaching the grid makes up
//   to 10 divisions and 3 roots on the shared units. a ray with a non-positive y
//   leaves at the check, a window reject after the window divisions, a sphere
//   miss at the discriminant; the next word is taken in the cycle after a result.
// reset
//   rst is synchronous. after it the grid memory is swept to zero, one cell a
//   cycle, all GRID_SIZE*GRID_SIZE cells (1048576), while req.ready stays low;
//   configuration writes are taken during the sweep.
// stalls
//   the result sits in an output register; the next item is accepted while it
//   waits, and the sequencer holds its finished result until rsp.ready frees
//   the register.
`default_nettype none

module ray_sphere_shade_accumulate_top
  import rss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  rss_req_if.sink          req,
  rss_rsp_if.source        rsp
);

  typedef enum logic [36:0] {
    ST_IDLE        = 37'h1 << 0,
    ST_RD_ADDR     = 37'h1 << 1,
    ST_RD_DATA     = 37'h1 << 2,
    ST_CHK         = 37'h1 << 3,
    ST_DX_GO       = 37'h1 << 4,
    ST_DX_WAIT     = 37'h1 << 5,
    ST_DZ_GO       = 37'h1 << 6,
    ST_DZ_WAIT     = 37'h1 << 7,
    ST_WIN         = 37'h1 << 8,
    ST_P           = 37'h1 << 9,
    ST_RR          = 37'h1 << 10,
    ST_CC          = 37'h1 << 11,
    ST_DISC        = 37'h1 << 12,
    ST_SQ_WAIT     = 37'h1 << 13,
    ST_PT0         = 37'h1 << 14,
    ST_PT1         = 37'h1 << 15,
    ST_PT2         = 37'h1 << 16,
    ST_PT_END      = 37'h1 << 17,
    ST_UV_MAG      = 37'h1 << 18,
    ST_UV_SQ0      = 37'h1 << 19,
    ST_UV_SQ1      = 37'h1 << 20,
    ST_UV_SQ2      = 37'h1 << 21,
    ST_UV_SQRT     = 37'h1 << 22,
    ST_UV_LEN      = 37'h1 << 23,
    ST_UV_DIV_GO   = 37'h1 << 24,
    ST_UV_DIV_WAIT = 37'h1 << 25,
    ST_DOT0        = 37'h1 << 26,
    ST_DOT1        = 37'h1 << 27,
    ST_DOT2        = 37'h1 << 28,
    ST_DOT_END     = 37'h1 << 29,
    ST_ROW_GO      = 37'h1 << 30,
    ST_ROW_WAIT    = 37'h1 << 31,
    ST_COL_GO      = 37'h1 << 32,
    ST_COL_WAIT    = 37'h1 << 33,
    ST_GR_RD       = 37'h1 << 34,
    ST_GR_WR       = 37'h1 << 35,
    ST_DONE        = 37'h1 << 36
  } state_t;

  state_t state;

  // configuration registers
  logic signed [31:0] light_x, light_y, light_z, center_y;
  logic [30:0]        radius, win_dist, win_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x  <= RST_LIGHT_X;
      light_y  <= RST_LIGHT_Y;
      light_z  <= RST_LIGHT_Z;
      center_y <= RST_CENTER_Y;
      radius   <= RST_RADIUS;
      win_dist <= RST_WIN_DIST;
      win_half <= RST_WIN_HALF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIGHT_X:  light_x  <= cfg_data;
        CFG_LIGHT_Y:  light_y  <= cfg_data;
        CFG_LIGHT_Z:  light_z  <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        CFG_RADIUS:   radius   <= cfg_data[30:0];
        CFG_WIN_DIST: win_dist <= cfg_data[30:0];
        CFG_WIN_HALF: win_half <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // shared units
  div_req_t  dreq;
  div_rsp_t  drsp;
  sqrt_req_t sreq;
  sqrt_rsp_t srsp;
  grid_req_t greq;
  logic [31:0] grid_rdata;
  logic        clearing;

  rss_div  u_div  (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  rss_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sreq), .rsp(srsp));
  rss_grid u_grid (.clk(clk), .rst(rst), .req(greq), .rd_data(grid_rdata),
                   .clearing(clearing));

  // working registers
  logic signed [17:0] vx, vy, vz;
  logic [GRID_AW-1:0] rd_addr;
  logic [DIV_NW-1:0]  qx, qz;
  logic [31:0]        off_x, off_z;
  logic signed [31:0] p_r;
  logic [63:0]        acc;
  logic signed [33:0] t_r;
  logic signed [33:0] pt0, pt1, pt2;
  logic signed [35:0] uv_in [3];
  logic [29:0]        ms [3];
  logic               uv_sel;
  logic [1:0]         comp_i;
  logic [SQ_RW-1:0]   len;
  logic signed [17:0] nrm [3];
  logic signed [17:0] sv [3];
  logic signed [35:0] dacc;
  logic [GRID_W-1:0]  row, col;

  // result being built
  logic        res_acc;
  logic [9:0]  res_row, res_col;
  logic [16:0] res_bright;
  logic [31:0] res_cell;

  // shared multiplier, product registered
  logic               mul_en;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  always_ff @(posedge clk) begin
    if (mul_en) mul_p <= mul_a * mul_b;
  end

  // helper views of the product and inputs
  logic signed [31:0] p_now;
  logic signed [33:0] pt_now;
  logic [16:0]        abs_vx, abs_vz;
  logic [35:0]        mag [3];
  logic [35:0]        mx;
  logic [2:0]         k;
  logic signed [35:0] dot;
  logic [19:0]        dot_sh;
  logic [16:0]        bright;
  logic [GRID_AW-1:0] cell_addr;
  logic [32:0]        cell_sum;
  logic [16:0]        uq;

  always_comb begin
    p_now  = mul_p[47:16];
    pt_now = mul_p[49:16];
    abs_vx = vx[17] ? 17'(-vx) : 17'(vx);
    abs_vz = vz[17] ? 17'(-vz) : 17'(vz);
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = uv_in[i][35] ? 36'(-uv_in[i]) : 36'(uv_in[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    // least shift that brings every magnitude below 2^30
    k = '0;
    for (int j = 0; j < 7; j++) begin
      if ((mx >> j) >= 36'h4000_0000) k = 3'(j + 1);
    end
    dot    = dacc + mul_p[35:0];
    dot_sh = dot[35:16];
    if (dot <= 0) bright = '0;
    else if (dot_sh > 20'(ONE_Q16)) bright = 17'(ONE_Q16);
    else bright = 17'(dot_sh);
    cell_addr = GRID_AW'(32'(row) * GRID_SIZE + 32'(col));
    cell_sum  = {1'b0, grid_rdata} + 33'(res_bright);
    uq        = drsp.quot[16:0];
  end

  // multiplier operand selection
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_CHK: begin
        mul_en = vy > 0;
        mul_a  = 34'(win_dist);
        mul_b  = 34'(abs_vx);
      end
      ST_DX_GO: begin
        mul_en = 1'b1;
        mul_a  = 34'(win_dist);
        mul_b  = 34'(abs_vz);
      end
      ST_WIN: begin
        mul_en = 1'b1;
        mul_a  = 34'(center_y);
        mul_b  = 34'(vy);
      end
      ST_P: begin
        mul_en = 1'b1;
        mul_a  = 34'(p_now);
        mul_b  = 34'(p_now);
      end
      ST_RR: begin
        mul_en = 1'b1;
        mul_a  = 34'(radius);
        mul_b  = 34'(radius);
      end
      ST_CC: begin
        mul_en = 1'b1;
        mul_a  = 34'(center_y);
        mul_b  = 34'(center_y);
      end
      ST_PT0: begin
        mul_en = 1'b1;
        mul_a  = t_r;
        mul_b  = 34'(vx);
      end
      ST_PT1: begin
        mul_en = 1'b1;
        mul_a  = t_r;
        mul_b  = 34'(vy);
      end
      ST_PT2: begin
        mul_en = 1'b1;
        mul_a  = t_r;
        mul_b  = 34'(vz);
      end
      ST_UV_SQ0: begin
        mul_en = 1'b1;
        mul_a  = 34'(ms[0]);
        mul_b  = 34'(ms[0]);
      end
      ST_UV_SQ1: begin
        mul_en = 1'b1;
        mul_a  = 34'(ms[1]);
        mul_b  = 34'(ms[1]);
      end
      ST_UV_SQ2: begin
        mul_en = 1'b1;
        mul_a  = 34'(ms[2]);
        mul_b  = 34'(ms[2]);
      end
      ST_DOT0: begin
        mul_en = 1'b1;
        mul_a  = 34'(nrm[0]);
        mul_b  = 34'(sv[0]);
      end
      ST_DOT1: begin
        mul_en = 1'b1;
        mul_a  = 34'(nrm[1]);
        mul_b  = 34'(sv[1]);
      end
      ST_DOT2: begin
        mul_en = 1'b1;
        mul_a  = 34'(nrm[2]);
        mul_b  = 34'(sv[2]);
      end
      default: ;
    endcase
  end

  // divider, root unit and grid requests
  always_comb begin
    dreq = '0;
    sreq = '0;
    greq = '0;
    case (state)
      ST_DX_GO, ST_DZ_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = mul_p[DIV_NW-1:0];
        dreq.divisor  = DIV_DW'(vy);
      end
      ST_UV_DIV_GO: begin
        dreq.start    = len != '0;
        dreq.dividend = DIV_NW'({ms[comp_i], 16'h0000});
        dreq.divisor  = len;
      end
      ST_ROW_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_NW'(DIV_NW'(off_x) * DIV_NW'(GRID_SIZE));
        dreq.divisor  = {win_half, 1'b0};
      end
      ST_COL_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_NW'(DIV_NW'(off_z) * DIV_NW'(GRID_SIZE));
        dreq.divisor  = {win_half, 1'b0};
      end
      ST_DISC: begin
        sreq.start    = acc > mul_p[63:0];
        sreq.radicand = acc - mul_p[63:0];
      end
      ST_UV_SQRT: begin
        sreq.start    = 1'b1;
        sreq.radicand = acc + mul_p[63:0];
      end
      ST_RD_ADDR: begin
        greq.rd   = 1'b1;
        greq.addr = rd_addr;
      end
      ST_GR_RD: begin
        greq.rd   = 1'b1;
        greq.addr = cell_addr;
      end
      ST_GR_WR: begin
        greq.wr   = 1'b1;
        greq.addr = cell_addr;
        greq.data = cell_sum[32] ? 32'hFFFF_FFFF : cell_sum[31:0];
      end
      default: ;
    endcase
  end

  assign req.ready = (state == ST_IDLE) && !clearing;

  logic out_free;
  assign out_free = !rsp.valid || rsp.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            vx         <= clamp_dir(req.dir_x);
            vy         <= clamp_dir(req.dir_y);
            vz         <= clamp_dir(req.dir_z);
            res_acc    <= 1'b0;
            res_row    <= '0;
            res_col    <= '0;
            res_bright <= '0;
            res_cell   <= '0;
            rd_addr    <= GRID_AW'(32'(req.read_row) * GRID_SIZE + 32'(req.read_col));
            if (req.opcode == OP_READ) begin
              // a cell outside the grid reads as zero
              if (32'(req.read_row) < GRID_SIZE && 32'(req.read_col) < GRID_SIZE)
                state <= ST_RD_ADDR;
              else
                state <= ST_DONE;
            end else begin
              state <= ST_CHK;
            end
          end
        end
        ST_RD_ADDR: state <= ST_RD_DATA;
        ST_RD_DATA: begin
          res_cell <= grid_rdata;
          state    <= ST_DONE;
        end
        ST_CHK: state <= (vy > 0) ? ST_DX_GO : ST_DONE;
        ST_DX_GO: state <= ST_DX_WAIT;
        ST_DX_WAIT: begin
          if (drsp.done) begin
            qx    <= drsp.quot;
            state <= ST_DZ_GO;
          end
        end
        ST_DZ_GO: state <= ST_DZ_WAIT;
        ST_DZ_WAIT: begin
          if (drsp.done) begin
            qz    <= drsp.quot;
            state <= ST_WIN;
          end
        end
        ST_WIN: begin
          if (qx < DIV_NW'(win_half) && qz < DIV_NW'(win_half)) begin
            off_x <= vx[17] ? 32'(win_half) - 32'(qx) : 32'(win_half) + 32'(qx);
            off_z <= vz[17] ? 32'(win_half) - 32'(qz) : 32'(win_half) + 32'(qz);
            state <= ST_P;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_P: begin
          p_r   <= p_now;
          state <= ST_RR;
        end
        ST_RR: begin
          acc   <= mul_p[63:0];
          state <= ST_CC;
        end
        ST_CC: begin
          acc   <= acc + mul_p[63:0];
          state <= ST_DISC;
        end
        ST_DISC: state <= (acc > mul_p[63:0]) ? ST_SQ_WAIT : ST_DONE;
        ST_SQ_WAIT: begin
          if (srsp.done) begin
            t_r   <= 34'(p_r) - 34'(srsp.root);
            state <= ST_PT0;
          end
        end
        ST_PT0: state <= ST_PT1;
        ST_PT1: begin
          pt0   <= pt_now;
          state <= ST_PT2;
        end
        ST_PT2: begin
          pt1   <= pt_now;
          state <= ST_PT_END;
        end
        ST_PT_END: begin
          // surface normal direction first
          pt2      <= pt_now;
          uv_in[0] <= 36'(pt0);
          uv_in[1] <= 36'(pt1) - 36'(center_y);
          uv_in[2] <= 36'(pt_now);
          uv_sel   <= 1'b0;
          state    <= ST_UV_MAG;
        end
        ST_UV_MAG: begin
          for (int i = 0; i < 3; i++) ms[i] <= 30'(mag[i] >> k);
          state <= ST_UV_SQ0;
        end
        ST_UV_SQ0: state <= ST_UV_SQ1;
        ST_UV_SQ1: begin
          acc   <= mul_p[63:0];
          state <= ST_UV_SQ2;
        end
        ST_UV_SQ2: begin
          acc   <= acc + mul_p[63:0];
          state <= ST_UV_SQRT;
        end
        ST_UV_SQRT: state <= ST_UV_LEN;
        ST_UV_LEN: begin
          if (srsp.done) begin
            len    <= srsp.root;
            comp_i <= '0;
            state  <= ST_UV_DIV_GO;
          end
        end
        ST_UV_DIV_GO, ST_UV_DIV_WAIT: begin
          // zero length vector gives zero components without a division
          if ((state == ST_UV_DIV_GO && len == '0) ||
              (state == ST_UV_DIV_WAIT && drsp.done)) begin
            if (uv_sel) sv[comp_i]  <= (len == '0) ? 18'sd0 :
                                       uv_in[comp_i][35] ? -18'(uq) : 18'(uq);
            else        nrm[comp_i] <= (len == '0) ? 18'sd0 :
                                       uv_in[comp_i][35] ? -18'(uq) : 18'(uq);
            if (comp_i == 2'd2) begin
              if (!uv_sel) begin
                // then the direction towards the light
                uv_in[0] <= 36'(light_x) - 36'(pt0);
                uv_in[1] <= 36'(light_y) - 36'(pt1);
                uv_in[2] <= 36'(light_z) - 36'(pt2);
                uv_sel   <= 1'b1;
                state    <= ST_UV_MAG;
              end else begin
                state <= ST_DOT0;
              end
            end else begin
              comp_i <= comp_i + 1'b1;
              state  <= ST_UV_DIV_GO;
            end
          end else if (state == ST_UV_DIV_GO) begin
            state <= ST_UV_DIV_WAIT;
          end
        end
        ST_DOT0: state <= ST_DOT1;
        ST_DOT1: begin
          dacc  <= mul_p[35:0];
          state <= ST_DOT2;
        end
        ST_DOT2: begin
          dacc  <= dacc + mul_p[35:0];
          state <= ST_DOT_END;
        end
        ST_DOT_END: begin
          res_bright <= bright;
          state      <= ST_ROW_GO;
        end
        ST_ROW_GO: state <= ST_ROW_WAIT;
        ST_ROW_WAIT: begin
          if (drsp.done) begin
            row   <= GRID_W'(GRID_SIZE - 1) - drsp.quot[GRID_W-1:0];
            state <= ST_COL_GO;
          end
        end
        ST_COL_GO: state <= ST_COL_WAIT;
        ST_COL_WAIT: begin
          if (drsp.done) begin
            col   <= drsp.quot[GRID_W-1:0];
            state <= ST_GR_RD;
          end
        end
        ST_GR_RD: state <= ST_GR_WR;
        ST_GR_WR: begin
          res_acc <= 1'b1;
          res_row <= 10'(row);
          res_col <= 10'(col);
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp.valid      <= 1'b1;
      rsp.accepted   <= res_acc;
      rsp.hit_row    <= res_row;
      rsp.hit_col    <= res_col;
      rsp.brightness <= res_bright;
      rsp.cell_value <= res_cell;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[tb/ray_sphere_shade_accumulate_top_test.sv]
// self-checking testbench for the ray/sphere shade accumulator top level
// drives trace and read words, predicts every result and compares it field by field
// depends on rss_pkg, rss_if and the ray_sphere_shade_accumulate_top rtl
`default_nettype none

module ray_sphere_shade_accumulate_top_test;
  import rss_pkg::*;

  typedef longint vec3_t [3];

  // one expected result word
  typedef struct {
    logic        accepted;
    logic [9:0]  hit_row;
    logic [9:0]  hit_col;
    logic [16:0] brightness;
    logic [31:0] cell_value;
  } shade_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  rss_req_if req_ch ();
  rss_rsp_if rsp_ch ();

  ray_sphere_shade_accumulate_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // own copy of the geometry registers
  logic [31:0] light_x_q, light_y_q, light_z_q, centre_y_q;
  logic [30:0] radius_q, win_dist_q, win_half_q;

  // sparse copy of the brightness grid, missing cells are zero
  int unsigned cell_sum [longint];
  // cells that rays have landed in, so reads can target them
  logic [19:0] lit_cells [$];

  shade_word_t shade_pending [$];
  int          error_count = 0;

  // receiver behaviour
  int hold_off_cycles = 0;
  bit no_idling       = 0;
  int rx_stall_left   = 0;
  int rx_run_left     = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // ---------------------------------------------------------------------------
  // arithmetic of the shader, kept in 64 bit like the intended datapath
  // ---------------------------------------------------------------------------

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // normalise: scale down below 2^30, true length, then divide each component
  function automatic void normalise(input vec3_t v, output vec3_t u);
    longint unsigned m [3];
    longint unsigned top, len2, len, q;
    int k;
    top  = 0;
    len2 = 0;
    k    = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = magnitude(v[i]);
      if (m[i] > top) top = m[i];
    end
    while ((top >> k) >= (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> k;
      len2 = len2 + m[i] * m[i];
    end
    len = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q    = (len != 0) ? (m[i] << 16) / len : 0;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  // works out the result word of one item and updates the grid copy
  function automatic shade_word_t shade_predict(input logic op, input logic [17:0] dx,
                                                input logic [17:0] dy, input logic [17:0] dz,
                                                input logic [9:0] rrow, input logic [9:0] rcol);
    shade_word_t     w;
    vec3_t           v, pt, ic, li, nrm, sv;
    longint          cy, p, t, wx, wz, dot;
    longint unsigned d, h, qx, qz, pp, rr, cc, disc, bright, row, col, idx, cell_new;
    logic [17:0]     raw [3];
    w   = '{default: '0};
    raw = '{dx, dy, dz};
    if (op == OP_READ) begin
      idx = longint'(rrow) * GRID_SIZE + rcol;
      if (rrow < GRID_SIZE && rcol < GRID_SIZE && cell_sum.exists(idx))
        w.cell_value = cell_sum[idx];
      return w;
    end
    // clamp to [-1.0, 1.0]
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(raw[i]));
      if (v[i] > ONE_Q16) v[i] = ONE_Q16;
      if (v[i] < -ONE_Q16) v[i] = -ONE_Q16;
    end
    // backward or sideways ray
    if (v[1] <= 0) return w;
    // window test
    d  = win_dist_q;
    h  = win_half_q;
    qx = d * magnitude(v[0]) / longint'(v[1]);
    qz = d * magnitude(v[2]) / longint'(v[1]);
    if (!(qx < h && qz < h)) return w;
    wx = (v[0] < 0) ? -longint'(qx) : longint'(qx);
    wz = (v[2] < 0) ? -longint'(qz) : longint'(qz);
    // sphere test, products wrap at 64 bits
    cy = longint'($signed(centre_y_q));
    p  = (v[1] * cy) >>> 16;
    pp = magnitude(p) * magnitude(p);
    rr = longint'(radius_q) * longint'(radius_q);
    cc = magnitude(cy) * magnitude(cy);
    if (pp + rr <= cc) return w;
    disc = pp + rr - cc;
    t    = p - longint'(int_sqrt(disc));
    for (int i = 0; i < 3; i++) pt[i] = (v[i] * t) >>> 16;
    ic[0] = pt[0];
    ic[1] = pt[1] - cy;
    ic[2] = pt[2];
    li[0] = longint'($signed(light_x_q)) - pt[0];
    li[1] = longint'($signed(light_y_q)) - pt[1];
    li[2] = longint'($signed(light_z_q)) - pt[2];
    normalise(ic, nrm);
    normalise(li, sv);
    dot = nrm[0] * sv[0] + nrm[1] * sv[1] + nrm[2] * sv[2];
    if (dot <= 0) begin
      bright = 0;
    end else begin
      bright = longint'(dot) >> 16;
      if (bright > ONE_Q16) bright = ONE_Q16;
    end
    row  = (GRID_SIZE - 1) - longint'(wx + longint'(h)) * GRID_SIZE / (2 * h);
    col  = longint'(wz + longint'(h)) * GRID_SIZE / (2 * h);
    idx  = row * GRID_SIZE + col;
    cell_new = (cell_sum.exists(idx) ? cell_sum[idx] : 0) + bright;
    if (cell_new > 64'hFFFF_FFFF) cell_new = 64'hFFFF_FFFF;
    cell_sum[idx] = cell_new[31:0];
    lit_cells.push_back({row[9:0], col[9:0]});
    w.accepted   = 1'b1;
    w.hit_row    = row[9:0];
    w.hit_col    = col[9:0];
    w.brightness = bright[16:0];
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      CFG_LIGHT_X:  light_x_q  = value;
      CFG_LIGHT_Y:  light_y_q  = value;
      CFG_LIGHT_Z:  light_z_q  = value;
      CFG_CENTER_Y: centre_y_q = value;
      CFG_RADIUS:   radius_q   = value[30:0];
      CFG_WIN_DIST: win_dist_q = value[30:0];
      CFG_WIN_HALF: win_half_q = value[30:0];
      default: ;
    endcase
  endtask

  task automatic write_geometry(input logic [31:0] lx, input logic [31:0] ly,
                                input logic [31:0] lz, input logic [31:0] cy,
                                input logic [31:0] rad, input logic [31:0] wdist,
                                input logic [31:0] half);
    write_reg(CFG_LIGHT_X, lx);
    write_reg(CFG_LIGHT_Y, ly);
    write_reg(CFG_LIGHT_Z, lz);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_WIN_DIST, wdist);
    write_reg(CFG_WIN_HALF, half);
  endtask

  // sends one word; valid stays high into the next call unless a gap is chosen
  task automatic send_word(input logic op, input logic [17:0] dx, input logic [17:0] dy,
                           input logic [17:0] dz, input logic [9:0] rrow,
                           input logic [9:0] rcol);
    if (!no_idling && $urandom_range(0, 5) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.opcode   = op;
    req_ch.dir_x    = dx;
    req_ch.dir_y    = dy;
    req_ch.dir_z    = dz;
    req_ch.read_row = rrow;
    req_ch.read_col = rcol;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    shade_pending.push_back(shade_predict(op, dx, dy, dz, rrow, rcol));
    @(negedge clk);
  endtask

  task automatic trace(input int dx, input int dy, input int dz);
    send_word(OP_TRACE, dx[17:0], dy[17:0], dz[17:0], 10'($urandom), 10'($urandom));
  endtask

  task automatic read_cell(input int rrow, input int rcol);
    send_word(OP_READ, 18'($urandom), 18'($urandom), 18'($urandom), rrow[9:0], rcol[9:0]);
  endtask

  // lowers valid and waits until every expected word has come back
  task automatic drain;
    req_ch.valid = 1'b0;
    while (shade_pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // ready pattern: long hold-off first, then random stall bursts, or always ready with no_idling
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (no_idling) begin
      rsp_ch.ready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_run_left > 0) begin
      rsp_ch.ready <= 1'b1;
      rx_run_left <= rx_run_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      rsp_ch.ready <= 1'b0;
      rx_stall_left <= $urandom_range(0, 17);
    end else begin
      rsp_ch.ready <= 1'b1;
      rx_run_left <= $urandom_range(0, 40);
    end
  end

  // compare each word against the oldest expectation
  always @(posedge clk) begin
    shade_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (shade_pending.size() == 0) begin
        report_mismatch("unexpected word", rsp_ch.cell_value, 0);
      end else begin
        want = shade_pending.pop_front();
        if (rsp_ch.accepted !== want.accepted)
          report_mismatch("accepted", rsp_ch.accepted, want.accepted);
        if (rsp_ch.hit_row !== want.hit_row)
          report_mismatch("hit_row", rsp_ch.hit_row, want.hit_row);
        if (rsp_ch.hit_col !== want.hit_col)
          report_mismatch("hit_col", rsp_ch.hit_col, want.hit_col);
        if (rsp_ch.brightness !== want.brightness)
          report_mismatch("brightness", rsp_ch.brightness, want.brightness);
        if (rsp_ch.cell_value !== want.cell_value)
          report_mismatch("cell_value", rsp_ch.cell_value, want.cell_value);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, every operation and the named corner cases
  task automatic test_directed;
    read_cell(0, 0);
    read_cell(1023, 1023);
    trace(0, 65536, 0);                 // straight at the sphere centre
    read_cell(511, 512);                // the cell it lands in
    trace(0, -65536, 0);                // backward ray
    trace(20000, 0, 0);                 // zero y component
    trace(65536, 100, 0);               // far outside the window
    trace(0, 100, -65536);
    trace(40000, 45000, 0);             // inside the window, misses the sphere
    trace(131071, 131071, 131071);      // clamped to +1.0, window edge
    trace(-131072, 131071, -131072);    // clamped to -1.0
    trace(-65536, 65536, 65535);
    trace(10000, 60000, -12000);
    trace(-20000, 50000, 15000);
    trace(0, 65536, 0);                 // same cell again, accumulates
    read_cell(511, 512);
    drain();
    // light sitting on the hit point: zero length light vector
    write_geometry(32'd0, 32'h0006_0000, 32'd0, RST_CENTER_Y, RST_RADIUS,
                   RST_WIN_DIST, RST_WIN_HALF);
    trace(0, 65536, 0);
    read_cell(511, 512);
    drain();
    // narrowest window: only dead-centre rays get in
    write_reg(CFG_WIN_HALF, 32'd1);
    trace(0, 65536, 0);
    trace(1, 65536, 0);
    drain();
  endtask

  // output held off while the sender keeps offering, then a full pause
  task automatic test_backpressure;
    write_geometry(RST_LIGHT_X, RST_LIGHT_Y, RST_LIGHT_Z, RST_CENTER_Y, RST_RADIUS,
                   RST_WIN_DIST, RST_WIN_HALF);
    hold_off_cycles = 400;
    for (int i = 0; i < 6; i++) read_cell($urandom_range(0, 1023), $urandom_range(0, 1023));
    trace(3000, 65000, -3000);
    trace(-3000, 65000, 3000);
    drain();
    hold_off_cycles = 1500;
    trace(1000, 65000, 2000);
    trace(-2000, 64000, 500);
    read_cell(511, 512);
    drain();
  endtask

  // random item: mostly rays aimed into the sphere cone, some noise, some reads
  task automatic random_item;
    int          sel, vy, span;
    logic [19:0] rc;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      vy   = $urandom_range(30000, 65536);
      span = vy * 3 / 5;
      trace($urandom_range(0, 2 * span) - span, vy, $urandom_range(0, 2 * span) - span);
    end else if (sel < 70) begin
      send_word(OP_TRACE, 18'($urandom), 18'($urandom), 18'($urandom), 10'($urandom),
                10'($urandom));
    end else if (sel < 85 && lit_cells.size() != 0) begin
      rc = lit_cells[$urandom_range(0, lit_cells.size() - 1)];
      read_cell(int'(rc[19:10]), int'(rc[9:0]));
    end else begin
      read_cell($urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  // several geometry settings, extremes among them
  task automatic test_random_phases;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_geometry(RST_LIGHT_X, RST_LIGHT_Y, RST_LIGHT_Z, RST_CENTER_Y, RST_RADIUS,
                          RST_WIN_DIST, RST_WIN_HALF);
        1: write_geometry(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0008_0000,
                          32'h0005_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        2: write_geometry(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000,
                          32'h0002_8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        3: write_geometry(32'hFFF0_0000, 32'h0000_0000, 32'h0010_0000, 32'hFFF4_0000,
                          32'h0000_0000, 32'h0001_0000, 32'h0000_8000);
        4: write_geometry(32'h0000_0000, 32'h0100_0000, 32'h0000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h0040_0000, 32'h0030_0000);
        default: write_geometry(32'h0002_0000, 32'hFFFE_0000, 32'h0003_0000, 32'h0010_0000,
                                32'h0009_0000, 32'h0005_0000, 32'h0004_0000);
      endcase
      no_idling = (ph == 5);
      repeat ((ph == 3) ? 100 : 290) random_item();
      drain();
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_LIGHT_X;
    cfg_data        = '0;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = OP_TRACE;
    req_ch.dir_x    = '0;
    req_ch.dir_y    = '0;
    req_ch.dir_z    = '0;
    req_ch.read_row = '0;
    req_ch.read_col = '0;
    rsp_ch.ready    = 1'b0;
    light_x_q  = RST_LIGHT_X;
    light_y_q  = RST_LIGHT_Y;
    light_z_q  = RST_LIGHT_Z;
    centre_y_q = RST_CENTER_Y;
    radius_q   = RST_RADIUS;
    win_dist_q = RST_WIN_DIST;
    win_half_q = RST_WIN_HALF;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_random_phases();

    // nothing may turn up after the last expected word
    repeat (700) @(negedge clk);
    if (error_count == 0 && shade_pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // grid sweep after reset plus the processing of every item, taken several times
  initial begin
    #60000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
